@@ hdl/point_in_polygon_test_defines.svh @@
// assertion macros for the point-in-polygon test block
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH

`ifndef SYNTHESIS

// condition must hold in the same cycle
`define PIP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pip check failed");

// condition must hold in the next cycle
`define PIP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pip check failed");

`else

`define PIP_ASSERT_NOW(lbl, ante, cons)
`define PIP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hdl/pip_pkg.sv @@
// package: types, constants and helpers of the point-in-polygon test block
package pip_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int MIN_VERTICES = 3;
	localparam int COORD_W      = 16;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int TOL_W        = 33;
	localparam int BOX_W        = 16;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int PROD_W       = 2 * DIFF_W;
	localparam int CROSS_W      = PROD_W + 1;
	localparam int BOXC_W       = COORD_W + 2;
	localparam int CFG_DATA_W   = TOL_W;

	// item modes
	typedef enum logic {
		MODE_WRITE = 1'b0,
		MODE_QUERY = 1'b1
	} mode_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_VERTEX_COUNT     = 2'd0,
		CFG_INCLUDE_BOUNDARY = 2'd1,
		CFG_COLLINEAR_TOL    = 2'd2,
		CFG_BOX_TOL          = 2'd3
	} cfg_idx_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_MUL1,
		ST_MUL2,
		ST_EVAL
	} state_t;

	typedef struct packed {
		logic                      mode;
		logic [IDX_W-1:0]          vertex_index;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
	} cmd_t;

	typedef struct packed {
		logic inside_res;
		logic on_boundary;
		logic too_few_vertices;
	} res_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} vtx_t;

	// exact difference of two coordinates
	function automatic logic signed [DIFF_W-1:0] coord_diff(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		return DIFF_W'(a) - DIFF_W'(b);
	endfunction

	// coordinate widened for box bounds
	function automatic logic signed [BOXC_W-1:0] box_ext(input logic signed [COORD_W-1:0] v);
		return BOXC_W'(v);
	endfunction

endpackage

@@ hdl/pip_ram.sv @@
// generic single-port ram with registered read
module pip_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write or registered read, one access a cycle
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

@@ hdl/pip_mul.sv @@
// shared signed multiplier with registered product
module pip_mul (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [pip_pkg::DIFF_W-1:0]  op_a,
	input  logic signed [pip_pkg::DIFF_W-1:0]  op_b,
	output logic signed [pip_pkg::PROD_W-1:0]  prod
);
	import pip_pkg::*;

	logic signed [PROD_W-1:0] prod_q;

	// one product per enabled cycle
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
		end
	end

	assign prod = prod_q;

endmodule

@@ hdl/point_in_polygon_test.sv @@
// top level: vertex store, edge walk sequencer and result register
//
//  channel  handshake              payload
//  cmd      start / busy           cmd (mode, vertex_index, coord_x, coord_y)
//  cfg      cfg_we                 cfg_idx, cfg_wdata
//  result   done (one cycle)       result (inside_res, on_boundary, too_few_vertices)
//
// a vertex write goes straight into the vertex memory and gives no result.
// a query with fewer than three vertices gives its result in the cycle after the beat.
// otherwise the sequencer reads the first vertex (ST_FIRST) and walks every edge
// through the one shared multiplier, in the states ST_MUL1 and ST_MUL2 (one product
// each) and then ST_EVAL; busy holds through the walk and done follows the last ST_EVAL.
// reset clears state, config and done; memory, datapath and payload are not cleared.
// the result receiver cannot stall; result holds until the next result is written.
`include "point_in_polygon_test_defines.svh"

module point_in_polygon_test (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  pip_pkg::cmd_t                    cmd,
	input  logic                             cfg_we,
	input  pip_pkg::cfg_idx_t                cfg_idx,
	input  logic [pip_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output logic                             done,
	output pip_pkg::res_t                    result
);
	import pip_pkg::*;

	// configuration registers
	logic [CNT_W-1:0] vcount_q;
	logic             incl_q;
	logic [TOL_W-1:0] coll_tol_q;
	logic [BOX_W-1:0] box_tol_q;

	// sequencer and datapath
	state_t                   state_q, state_d;
	vtx_t                     pt_q, v0_q, a_q, b_q, b_sel;
	logic [CNT_W-1:0]         n_q, n_sat;
	logic [IDX_W-1:0]         k_q;
	logic signed [PROD_W-1:0] t1_q, prod;
	logic                     box_ok_q, ycross_q, dy_pos_q;
	logic                     onb_q, par_q;
	logic                     done_q;
	res_t                     res_q;

	logic                     accept, is_query, few, last;
	logic                     ram_en, ram_we;
	logic [IDX_W-1:0]         ram_addr;
	logic [$bits(vtx_t)-1:0]  ram_rdata;
	logic                     mul_en;
	logic signed [DIFF_W-1:0] mul_a, mul_b;

	logic signed [COORD_W-1:0] min_x, max_x, min_y, max_y;
	logic signed [BOXC_W-1:0]  margin;
	logic                      box_ok;
	logic signed [CROSS_W-1:0] cross_d;
	logic [CROSS_W-1:0]        cross_mag;
	logic                      edge_hit, cross_hit, onb_new, par_new;

	// vertex memory, x and y side by side
	pip_ram #(
		.WIDTH($bits(vtx_t)),
		.DEPTH(MAX_VERTICES)
	) u_vtx_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata ({cmd.coord_x, cmd.coord_y}),
		.rdata (ram_rdata)
	);

	// shared multiplier
	pip_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	// beat and query decode
	assign accept   = start && !busy;
	assign is_query = (cmd.mode == MODE_QUERY);
	assign n_sat    = (vcount_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount_q;
	assign few      = (n_sat < CNT_W'(MIN_VERTICES));
	assign last     = (CNT_W'(k_q) == n_q - CNT_W'(1));
	assign b_sel    = last ? v0_q : vtx_t'(ram_rdata);
	assign busy     = (state_q != ST_IDLE);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q   <= '0;
			incl_q     <= 1'b0;
			coll_tol_q <= '0;
			box_tol_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_VERTEX_COUNT:     vcount_q   <= cfg_wdata[CNT_W-1:0];
				CFG_INCLUDE_BOUNDARY: incl_q     <= cfg_wdata[0];
				CFG_COLLINEAR_TOL:    coll_tol_q <= cfg_wdata[TOL_W-1:0];
				CFG_BOX_TOL:          box_tol_q  <= cfg_wdata[BOX_W-1:0];
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory and multiplier control
	always_comb begin
		state_d  = state_q;
		ram_en   = 1'b0;
		ram_we   = 1'b0;
		ram_addr = cmd.vertex_index;
		mul_en   = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!is_query) begin
						ram_en = 1'b1;
						ram_we = 1'b1;
					end else if (!few) begin
						ram_en   = 1'b1;
						ram_addr = '0;
						state_d  = ST_FIRST;
					end
				end
			end
			ST_FIRST: begin
				ram_en   = 1'b1;
				ram_addr = IDX_W'(1);
				state_d  = ST_MUL1;
			end
			ST_MUL1: begin
				mul_en  = 1'b1;
				mul_a   = coord_diff(b_sel.x, a_q.x);
				mul_b   = coord_diff(pt_q.y, a_q.y);
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				mul_en   = 1'b1;
				mul_a    = coord_diff(b_q.y, a_q.y);
				mul_b    = coord_diff(pt_q.x, a_q.x);
				ram_en   = 1'b1;
				ram_addr = k_q + IDX_W'(2);
				state_d  = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = last ? ST_IDLE : ST_MUL1;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// edge bounding box grown by the margin
	always_comb begin
		min_x  = (a_q.x < b_q.x) ? a_q.x : b_q.x;
		max_x  = (a_q.x > b_q.x) ? a_q.x : b_q.x;
		min_y  = (a_q.y < b_q.y) ? a_q.y : b_q.y;
		max_y  = (a_q.y > b_q.y) ? a_q.y : b_q.y;
		margin = $signed(BOXC_W'(box_tol_q));
		box_ok = (box_ext(pt_q.x) >= box_ext(min_x) - margin) &&
			(box_ext(pt_q.x) <= box_ext(max_x) + margin) &&
			(box_ext(pt_q.y) >= box_ext(min_y) - margin) &&
			(box_ext(pt_q.y) <= box_ext(max_y) + margin);
	end

	// cross product, collinear test and ray crossing
	always_comb begin
		cross_d   = CROSS_W'(t1_q) - CROSS_W'(prod);
		cross_mag = cross_d[CROSS_W-1] ? CROSS_W'(-cross_d) : CROSS_W'(cross_d);
		edge_hit  = box_ok_q && (cross_mag <= CROSS_W'(coll_tol_q));
		cross_hit = ycross_q && (dy_pos_q ? (!cross_d[CROSS_W-1] && (cross_d != '0))
			: cross_d[CROSS_W-1]);
		onb_new   = onb_q || (incl_q && edge_hit);
		par_new   = par_q ^ cross_hit;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_query) begin
					pt_q.x <= cmd.coord_x;
					pt_q.y <= cmd.coord_y;
					n_q    <= n_sat;
				end
			end
			ST_FIRST: begin
				v0_q  <= vtx_t'(ram_rdata);
				a_q   <= vtx_t'(ram_rdata);
				k_q   <= '0;
				onb_q <= 1'b0;
				par_q <= 1'b0;
			end
			ST_MUL1: begin
				b_q <= b_sel;
			end
			ST_MUL2: begin
				t1_q     <= prod;
				box_ok_q <= box_ok;
				ycross_q <= (a_q.y > pt_q.y) != (b_q.y > pt_q.y);
				dy_pos_q <= (b_q.y > a_q.y);
			end
			ST_EVAL: begin
				a_q   <= b_q;
				k_q   <= k_q + IDX_W'(1);
				onb_q <= onb_new;
				par_q <= par_new;
			end
			default: begin
			end
		endcase
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && is_query && few) || (state_q == ST_EVAL && last);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept && is_query && few) begin
			res_q <= '{inside_res: 1'b0, on_boundary: 1'b0, too_few_vertices: 1'b1};
		end else if (state_q == ST_EVAL && last) begin
			if (onb_new) begin
				res_q <= '{inside_res: 1'b1, on_boundary: 1'b1, too_few_vertices: 1'b0};
			end else begin
				res_q <= '{inside_res: par_new, on_boundary: 1'b0, too_few_vertices: 1'b0};
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

	// a result only appears with the sequencer back at rest
	`PIP_ASSERT_NOW(a_done_when_idle, done, !busy)
	// a query with enough vertices starts the edge walk
	`PIP_ASSERT_NEXT(a_query_walks, accept && is_query && !few, busy)
	// a vertex write never produces a result
	`PIP_ASSERT_NEXT(a_write_silent, accept && !is_query, !done)
	// the edge counter stays below the vertex count during the walk
	`PIP_ASSERT_NOW(a_edge_in_range, busy && (state_q != ST_FIRST), CNT_W'(k_q) < n_q)

endmodule
